### hw/rtl/matp_pkg.sv
// Package: widths, register map, payload types and constants for the moist air block.
package matp_pkg;

	localparam int REG_W   = 25;
	localparam int FRAC_W  = 25;
	localparam int DRY_W   = 29;
	localparam int PROD_W  = DRY_W + REG_W + 1;
	localparam int SUM_W   = PROD_W + 2;
	localparam int CV_W    = 30;
	localparam int CVU_W   = 29;
	localparam int RM_W    = 27;
	localparam int NUM_W   = 53;
	localparam int QUO_W   = 26;
	localparam int RHO_W   = 26;
	localparam int TEMP_W  = 25;
	localparam int PRES_W  = 24;
	localparam int DRYO_W  = 28;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int NUM_LANES = 6;

	localparam logic [2:0] REG_CV_DRY    = 3'd0;
	localparam logic [2:0] REG_GAS_DRY   = 3'd1;
	localparam logic [2:0] REG_GAS_VAPOR = 3'd2;
	localparam logic [2:0] REG_CV_VAPOR  = 3'd3;
	localparam logic [2:0] REG_CV_LIQUID = 3'd4;
	localparam logic [2:0] REG_CV_ICE    = 3'd5;

	localparam logic [REG_W-1:0] RST_CV_DRY    = 25'd2939290;
	localparam logic [REG_W-1:0] RST_GAS_DRY   = 25'd1175716;
	localparam logic [REG_W-1:0] RST_GAS_VAPOR = 25'd1890140;
	localparam logic [REG_W-1:0] RST_CV_VAPOR  = 25'd5669314;
	localparam logic [REG_W-1:0] RST_CV_LIQUID = 25'd17276928;
	localparam logic [REG_W-1:0] RST_CV_ICE    = 25'd8216576;

	localparam logic signed [DRY_W-1:0]  ONE_Q24  = 29'sd16777216;
	localparam logic signed [DRY_W-1:0]  DRY_MIN  = -29'sd134217728;
	localparam logic signed [DRYO_W-1:0] DRYO_MIN = 28'sh8000000;
	localparam logic [TEMP_W-1:0] TEMP_MAX = 25'h1FFFFFF;
	localparam logic [PRES_W-1:0] PRES_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [31:0]       energy_density;
		logic [RHO_W-1:0]  air_density;
		logic [FRAC_W-1:0] frac_vapor;
		logic [FRAC_W-1:0] frac_cloud;
		logic [FRAC_W-1:0] frac_rain;
		logic [FRAC_W-1:0] frac_ice;
		logic [FRAC_W-1:0] frac_snow;
		logic [FRAC_W-1:0] frac_graupel;
	} sample_t;

	typedef struct packed {
		logic signed [DRYO_W-1:0] dry_fraction;
		logic signed [31:0]       heat_capacity;
		logic [TEMP_W-1:0]        temperature;
		logic [PRES_W-1:0]        pressure;
		logic                     saturated;
	} result_t;

	// travels alongside the divider
	typedef struct packed {
		logic signed [DRYO_W-1:0] dry_out;
		logic                     dry_sat;
		logic signed [31:0]       cv_out;
		logic                     cv_bad;
		logic                     rm_bad;
		logic [RM_W-1:0]          rm;
		logic [RHO_W-1:0]         rho;
	} side_t;

	typedef struct packed {
		logic [CVU_W-1:0] cv;
		logic [CVU_W-1:0] rem;
		logic [QUO_W-1:0] lo;
		logic [QUO_W-1:0] quo;
		logic             ovf;
		side_t            side;
	} div_stage_t;

endpackage

### hw/rtl/moist_air_temp_pressure.sv
// Top level: register port, product lanes, merge, divider and pressure stages.
//
//  channel   handshake         payload            notes
//  input     start / busy      sample (sample_t)  busy is held low
//  result    done (strobe)     res (result_t)     one cycle, cannot be held off
//  config    APB psel/penable  paddr/pwdata       pready always high
//
// A transaction is taken every cycle; each result follows its start through the
// lane, merge and 27-stage divider (an overflow check, then one quotient bit per
// stage) and the two-step pressure multiply stages.
// Reset clears the valid pipeline and loads the register defaults.
// The receiver cannot stall, so nothing ever backs up.
module moist_air_temp_pressure (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  matp_pkg::sample_t             sample,
	output logic                          done,
	output matp_pkg::result_t             res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [matp_pkg::ADDR_W-1:0]   paddr,
	input  logic [matp_pkg::DATA_W-1:0]   pwdata,
	output logic [matp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import matp_pkg::*;

	localparam int LATENCY = 35;

	// ---------------- registers
	logic [REG_W-1:0] cv_dry_q, gas_dry_q, gas_vapor_q, cv_vapor_q, cv_liquid_q, cv_ice_q;
	logic [2:0]       reg_idx;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_dry_q    <= RST_CV_DRY;
			gas_dry_q   <= RST_GAS_DRY;
			gas_vapor_q <= RST_GAS_VAPOR;
			cv_vapor_q  <= RST_CV_VAPOR;
			cv_liquid_q <= RST_CV_LIQUID;
			cv_ice_q    <= RST_CV_ICE;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_CV_DRY:    cv_dry_q    <= pwdata[REG_W-1:0];
				REG_GAS_DRY:   gas_dry_q   <= pwdata[REG_W-1:0];
				REG_GAS_VAPOR: gas_vapor_q <= pwdata[REG_W-1:0];
				REG_CV_VAPOR:  cv_vapor_q  <= pwdata[REG_W-1:0];
				REG_CV_LIQUID: cv_liquid_q <= pwdata[REG_W-1:0];
				REG_CV_ICE:    cv_ice_q    <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CV_DRY:    prdata = DATA_W'(cv_dry_q);
			REG_GAS_DRY:   prdata = DATA_W'(gas_dry_q);
			REG_GAS_VAPOR: prdata = DATA_W'(gas_vapor_q);
			REG_CV_VAPOR:  prdata = DATA_W'(cv_vapor_q);
			REG_CV_LIQUID: prdata = DATA_W'(cv_liquid_q);
			REG_CV_ICE:    prdata = DATA_W'(cv_ice_q);
			default:       prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// ---------------- s1: fraction sums and dry fraction
	logic                    v_s1;
	logic signed [DRY_W-1:0] dry_s1, qv_s1, ql_s1, qi_s1;
	logic signed [DRYO_W-1:0] dry_out_s1;
	logic                    dry_sat_s1;
	logic [31:0]             energy_s1;
	logic [RHO_W-1:0]        rho_s1;
	logic [FRAC_W:0]         ql_c;
	logic [FRAC_W+1:0]       qi_c;
	logic [DRY_W-2:0]        qsum_c;
	logic signed [DRY_W-1:0] dry_c;

	always_comb begin
		ql_c   = {1'b0, sample.frac_cloud} + {1'b0, sample.frac_rain};
		qi_c   = {2'b00, sample.frac_ice} + {2'b00, sample.frac_snow}
			+ {2'b00, sample.frac_graupel};
		qsum_c = (DRY_W-1)'(sample.frac_vapor) + (DRY_W-1)'(ql_c) + (DRY_W-1)'(qi_c);
		dry_c  = ONE_Q24 - $signed({1'b0, qsum_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dry_s1     <= dry_c;
		qv_s1      <= $signed(DRY_W'(sample.frac_vapor));
		ql_s1      <= $signed(DRY_W'(ql_c));
		qi_s1      <= $signed(DRY_W'(qi_c));
		dry_sat_s1 <= dry_c < DRY_MIN;
		dry_out_s1 <= (dry_c < DRY_MIN) ? DRYO_MIN : dry_c[DRYO_W-1:0];
		energy_s1  <= sample.energy_density;
		rho_s1     <= sample.air_density;
	end

	// ---------------- s2: product lanes
	logic signed [DRY_W-1:0]  lane_a    [0:NUM_LANES-1];
	logic [REG_W-1:0]         lane_coef [0:NUM_LANES-1];
	logic signed [PROD_W-1:0] lane_p    [0:NUM_LANES-1];

	assign lane_a[0] = dry_s1;  assign lane_coef[0] = cv_dry_q;
	assign lane_a[1] = qv_s1;   assign lane_coef[1] = cv_vapor_q;
	assign lane_a[2] = ql_s1;   assign lane_coef[2] = cv_liquid_q;
	assign lane_a[3] = qi_s1;   assign lane_coef[3] = cv_ice_q;
	assign lane_a[4] = dry_s1;  assign lane_coef[4] = gas_dry_q;
	assign lane_a[5] = qv_s1;   assign lane_coef[5] = gas_vapor_q;

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		matp_lane u_lane (
			.clk  (clk),
			.a    (lane_a[l]),
			.coef (lane_coef[l]),
			.p_s2 (lane_p[l])
		);
	end

	logic                     v_s2, dry_sat_s2;
	logic signed [DRYO_W-1:0] dry_out_s2;
	logic [31:0]              energy_s2;
	logic [RHO_W-1:0]         rho_s2;

	// ---------------- s3: pair sums
	logic                      v_s3, dry_sat_s3;
	logic signed [DRYO_W-1:0]  dry_out_s3;
	logic [31:0]               energy_s3;
	logic [RHO_W-1:0]          rho_s3;
	logic signed [PROD_W:0]    cva_s3, cvb_s3, rms_s3;

	always_ff @(posedge clk) begin
		dry_sat_s2 <= dry_sat_s1;
		dry_out_s2 <= dry_out_s1;
		energy_s2  <= energy_s1;
		rho_s2     <= rho_s1;
		cva_s3     <= (PROD_W+1)'(lane_p[0]) + (PROD_W+1)'(lane_p[1]);
		cvb_s3     <= (PROD_W+1)'(lane_p[2]) + (PROD_W+1)'(lane_p[3]);
		rms_s3     <= (PROD_W+1)'(lane_p[4]) + (PROD_W+1)'(lane_p[5]);
		dry_sat_s3 <= dry_sat_s2;
		dry_out_s3 <= dry_out_s2;
		energy_s3  <= energy_s2;
		rho_s3     <= rho_s2;
	end

	// ---------------- s4: merge, round, divider operands
	logic signed [SUM_W-1:0] cv_acc, rm_acc;
	logic signed [SUM_W-25:0] cv_full, rm_full;
	logic signed [CV_W-1:0]  cv_c;
	logic                    v_s4;
	logic [NUM_W-1:0]        num_s4;
	logic [CVU_W-1:0]        cvu_s4;
	side_t                   side_s4;

	always_comb begin
		cv_acc  = SUM_W'(cva_s3) + SUM_W'(cvb_s3) + SUM_W'(25'sh0800000);
		rm_acc  = SUM_W'(rms_s3) + SUM_W'(25'sh0800000);
		cv_full = cv_acc[SUM_W-1:24];
		rm_full = rm_acc[SUM_W-1:24];
		cv_c    = cv_full[CV_W-1:0];
	end

	always_ff @(posedge clk) begin
		num_s4          <= {1'b0, energy_s3, 20'd0} + NUM_W'(cv_c[CVU_W-1:1]);
		cvu_s4          <= cv_c[CVU_W-1:0];
		side_s4.dry_out <= dry_out_s3;
		side_s4.dry_sat <= dry_sat_s3;
		side_s4.cv_out  <= {{(32-CV_W){cv_c[CV_W-1]}}, cv_c};
		side_s4.cv_bad  <= cv_full[SUM_W-25] || (cv_full == '0);
		side_s4.rm_bad  <= rm_full[SUM_W-25] || (rm_full == '0);
		side_s4.rm      <= rm_full[RM_W-1:0];
		side_s4.rho     <= rho_s3;
	end

	// ---------------- divider
	logic             dv_valid, dv_ovf;
	logic [QUO_W-1:0] dv_quo;
	side_t            dv_side;

	matp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (num_s4),
		.cv        (cvu_s4),
		.side      (side_s4),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.ovf       (dv_ovf),
		.side_o    (dv_side)
	);

	// ---------------- s5..s8: temperature and pressure
	logic                   t_over, v_s5, tsat_s5, v_s6, tsat_s6, v_s7, tsat_s7;
	logic [TEMP_W-1:0]      temp_c, temp_s5, temp_s6, temp_s7;
	logic [RHO_W+TEMP_W-1:0] prod_s5;
	logic [RHO_W+TEMP_W:0]  rt_acc;
	logic [34:0]            rt_s6;
	logic [RM_W+17:0]       pp_lo_s7;
	logic [RM_W+16:0]       pp_hi_s7;
	side_t                  side_s5, side_s6, side_s7;
	logic [62:0]            p_acc;
	logic [30:0]            pres_full;
	logic                   psat;
	logic [PRES_W-1:0]      pres_c;
	logic                   sat_c;

	always_comb begin
		t_over = dv_ovf || dv_quo[QUO_W-1];
		temp_c = (dv_side.cv_bad || t_over) ? TEMP_MAX : dv_quo[TEMP_W-1:0];
		rt_acc = {1'b0, prod_s5} + (RHO_W+TEMP_W+1)'(1 << 15);
	end

	always_ff @(posedge clk) begin
		temp_s5  <= temp_c;
		tsat_s5  <= !dv_side.cv_bad && t_over;
		prod_s5  <= (RHO_W+TEMP_W)'(dv_side.rho) * (RHO_W+TEMP_W)'(temp_c);
		side_s5  <= dv_side;
		rt_s6    <= rt_acc[50:16];
		temp_s6  <= temp_s5;
		tsat_s6  <= tsat_s5;
		side_s6  <= side_s5;
		pp_lo_s7 <= (RM_W+18)'(rt_s6[17:0]) * (RM_W+18)'(side_s6.rm);
		pp_hi_s7 <= (RM_W+17)'(rt_s6[34:18]) * (RM_W+17)'(side_s6.rm);
		temp_s7  <= temp_s6;
		tsat_s7  <= tsat_s6;
		side_s7  <= side_s6;
	end

	always_comb begin
		p_acc     = {1'b0, pp_hi_s7, 18'd0} + 63'(pp_lo_s7) + (63'(1) << 31);
		pres_full = p_acc[62:32];
		psat      = pres_full > 31'(PRES_MAX);
		if (side_s7.cv_bad) begin
			pres_c = PRES_MAX;
		end else if (side_s7.rm_bad) begin
			pres_c = '0;
		end else if (psat) begin
			pres_c = PRES_MAX;
		end else begin
			pres_c = pres_full[PRES_W-1:0];
		end
		sat_c = side_s7.dry_sat || side_s7.cv_bad || tsat_s7
			|| (!side_s7.cv_bad && (side_s7.rm_bad || psat));
	end

	always_ff @(posedge clk) begin
		res.dry_fraction  <= side_s7.dry_out;
		res.heat_capacity <= side_s7.cv_out;
		res.temperature   <= temp_s7;
		res.pressure      <= pres_c;
		res.saturated     <= sat_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= dv_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// ---------------- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result strobe missing after fixed latency");

	a_cv_bad: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.heat_capacity <= 0) |->
			res.saturated && (res.temperature == TEMP_MAX) && (res.pressure == PRES_MAX))
		else $error("non-positive capacity not saturated");

	a_dry_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.dry_fraction <= 28'sd16777216)
		else $error("dry fraction above one");

	a_dry_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.dry_fraction == DRYO_MIN) |-> res.saturated)
		else $error("clamped dry fraction without flag");

endmodule

### hw/rtl/matp_lane.sv
// One product lane: signed fraction times an unsigned capacity or gas constant.
module matp_lane (
	input  logic                               clk,
	input  logic signed [matp_pkg::DRY_W-1:0]  a,
	input  logic [matp_pkg::REG_W-1:0]         coef,
	output logic signed [matp_pkg::PROD_W-1:0] p_s2
);
	import matp_pkg::*;

	always_ff @(posedge clk) begin
		p_s2 <= PROD_W'(a) * $signed({1'b0, coef});
	end

endmodule

### hw/rtl/matp_div.sv
// Pipelined restoring divider: an overflow check stage, then one quotient bit per stage.
module matp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [matp_pkg::NUM_W-1:0]    num,
	input  logic [matp_pkg::CVU_W-1:0]    cv,
	input  matp_pkg::side_t               side,
	output logic                          out_valid,
	output logic [matp_pkg::QUO_W-1:0]    quo,
	output logic                          ovf,
	output matp_pkg::side_t               side_o
);
	import matp_pkg::*;

	localparam int STAGES = QUO_W + 1;

	div_stage_t        st_q [0:STAGES-1];
	logic [STAGES-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	// top bits already at or above the divisor: quotient needs more than QUO_W bits
	always_ff @(posedge clk) begin
		st_q[0].cv   <= cv;
		st_q[0].rem  <= {2'b00, num[NUM_W-1:QUO_W]};
		st_q[0].ovf  <= {2'b00, num[NUM_W-1:QUO_W]} >= cv;
		st_q[0].lo   <= num[QUO_W-1:0];
		st_q[0].quo  <= '0;
		st_q[0].side <= side;
	end

	for (genvar k = 1; k < STAGES; k++) begin : g_step
		logic [CVU_W:0]   trial;
		logic             ge;
		div_stage_t       nxt;

		always_comb begin
			trial            = {st_q[k-1].rem, st_q[k-1].lo[QUO_W-k]};
			ge               = trial >= {1'b0, st_q[k-1].cv};
			nxt              = st_q[k-1];
			nxt.rem          = ge ? CVU_W'(trial - {1'b0, st_q[k-1].cv}) : trial[CVU_W-1:0];
			nxt.quo[QUO_W-k] = ge;
		end

		always_ff @(posedge clk) begin
			st_q[k] <= nxt;
		end
	end

	assign out_valid = vld_q[STAGES-1];
	assign quo       = st_q[STAGES-1].quo;
	assign ovf       = st_q[STAGES-1].ovf;
	assign side_o    = st_q[STAGES-1].side;

endmodule

### tb/tb_top.sv
// Self-checking testbench for moist_air_temp_pressure: table-driven cells, then random phases.
module tb_top;
	import matp_pkg::*;

	localparam int LATENCY    = 35;
	localparam int DRAIN_WAIT = LATENCY + 8;
	localparam int QUIET_MAX  = 2000;
	localparam int ITEMS_PER_PHASE = 220;
	localparam int NUM_PHASES = 8;
	localparam int SAMPLE_BITS = $bits(sample_t);
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct {
		sample_t smp;
		bit      typed;
		result_t want;
	} cell_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sample_t sample = '0;
	logic done;
	result_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// shadow copy of the coefficient registers
	logic [REG_W-1:0] coef [6];
	result_t pending_results [$];
	int errors = 0;
	int cells_sent = 0;
	int results_seen = 0;
	int quiet = 0;

	moist_air_temp_pressure dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .res(res), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t thermo_of(sample_t s);
		result_t r;
		longint qv, ql, qi, dry, dout, cv, rm;
		longint c_dry, c_vap, c_liq, c_ice, g_dry, g_vap;
		longint unsigned en, rho, ucv, temp, pres, rt;
		bit sat;
		c_dry = coef[REG_CV_DRY];
		c_vap = coef[REG_CV_VAPOR];
		c_liq = coef[REG_CV_LIQUID];
		c_ice = coef[REG_CV_ICE];
		g_dry = coef[REG_GAS_DRY];
		g_vap = coef[REG_GAS_VAPOR];
		en  = s.energy_density;
		rho = s.air_density;
		qv  = s.frac_vapor;
		ql  = longint'(s.frac_cloud) + longint'(s.frac_rain);
		qi  = longint'(s.frac_ice) + longint'(s.frac_snow) + longint'(s.frac_graupel);
		sat = 1'b0;
		dry = 64'sd16777216 - qv - ql - qi;
		dout = dry;
		if (dout > 134217727) begin
			dout = 134217727;
			sat = 1'b1;
		end
		if (dout < -134217728) begin
			dout = -134217728;
			sat = 1'b1;
		end
		cv = (dry * c_dry + qv * c_vap + ql * c_liq + qi * c_ice + (64'sd1 <<< 23)) >>> 24;
		if (cv <= 0) begin
			sat = 1'b1;
			temp = TEMP_MAX;
			pres = PRES_MAX;
		end else begin
			ucv = cv;
			temp = ((en << 20) + (ucv >> 1)) / ucv;
			if (temp > TEMP_MAX) begin
				temp = TEMP_MAX;
				sat = 1'b1;
			end
			rm = (dry * g_dry + qv * g_vap + (64'sd1 <<< 23)) >>> 24;
			if (rm <= 0) begin
				pres = 0;
				sat = 1'b1;
			end else begin
				rt = (rho * temp + (64'd1 << 15)) >> 16;
				pres = (rt * longint'(rm) + (64'd1 << 31)) >> 32;
				if (pres > PRES_MAX) begin
					pres = PRES_MAX;
					sat = 1'b1;
				end
			end
		end
		r.dry_fraction  = dout[DRYO_W-1:0];
		r.heat_capacity = cv[31:0];
		r.temperature   = temp[TEMP_W-1:0];
		r.pressure      = pres[PRES_W-1:0];
		r.saturated     = sat;
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// results are valid for one cycle only
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result, actual %p", $time, res);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("dry_fraction", want.dry_fraction, res.dry_fraction);
				check_field("heat_capacity", want.heat_capacity, res.heat_capacity);
				check_field("temperature", want.temperature, res.temperature);
				check_field("pressure", want.pressure, res.pressure);
				check_field("saturated", want.saturated, res.saturated);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, quiet);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_cell(sample_t s, bit typed, result_t want);
		start <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(typed ? want : thermo_of(s));
		cells_sent++;
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_coef(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx <= REG_CV_ICE)
			coef[idx] = val[REG_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic sample_t random_cell();
		sample_t s;
		int unsigned left;
		s = SAMPLE_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		if ($urandom_range(0, 3) != 0) begin
			// physically plausible cell, water fractions sum below one
			left = 1 << 24;
			s.frac_vapor = FRAC_W'($urandom_range(0, left / 8));
			left -= s.frac_vapor;
			s.frac_cloud = FRAC_W'($urandom_range(0, left / 16));
			left -= s.frac_cloud;
			s.frac_rain = FRAC_W'($urandom_range(0, left / 16));
			left -= s.frac_rain;
			s.frac_ice = FRAC_W'($urandom_range(0, left / 16));
			left -= s.frac_ice;
			s.frac_snow = FRAC_W'($urandom_range(0, left / 16));
			left -= s.frac_snow;
			s.frac_graupel = FRAC_W'($urandom_range(0, left / 16));
			s.air_density = RHO_W'($urandom_range(0, 1 << 25));
			if ($urandom_range(0, 7) != 0)
				s.energy_density = $urandom_range(0, 200000000);
		end else if ($urandom_range(0, 1) == 0) begin
			s.frac_vapor = FRAC_W'($urandom_range(0, 1 << 24));
			s.frac_cloud = FRAC_W'($urandom_range(0, 1 << 24));
			s.frac_rain = FRAC_W'($urandom_range(0, 1 << 24));
			s.frac_ice = FRAC_W'($urandom_range(0, 1 << 24));
			s.frac_snow = FRAC_W'($urandom_range(0, 1 << 24));
			s.frac_graupel = FRAC_W'($urandom_range(0, 1 << 24));
		end
		return s;
	endfunction

	task automatic load_table(ref cell_row_t rows [$]);
		cell_row_t r;
		sample_t z;
		z = '0;
		r.typed = 1'b1;
		r.smp = z;
		r.want = '{28'sd16777216, 32'sd2939290, 25'd0, 24'd0, 1'b0};
		rows.push_back(r);
		r.smp = z;
		r.smp.energy_density = 32'hFFFFFFFF;
		r.want = '{28'sd16777216, 32'sd2939290, TEMP_MAX, 24'd0, 1'b1};
		rows.push_back(r);
		r.smp = z;
		r.smp.frac_cloud = 25'd16777216;
		r.want = '{28'sd0, 32'sd17276928, 25'd0, 24'd0, 1'b1};
		rows.push_back(r);
		r.typed = 1'b0;
		r.want = '0;
		for (int i = 0; i < 6; i++) begin
			r.smp = z;
			r.smp.energy_density = 32'd40000000;
			r.smp.air_density = 26'd16777216;
			r.smp[i*FRAC_W +: FRAC_W] = 25'd16777216;
			rows.push_back(r);
		end
		r.smp = z;
		r.smp.energy_density = 32'd1000000;
		r.smp.air_density = 26'd16777216;
		r.smp.frac_vapor = 25'd16777216;
		r.smp.frac_cloud = 25'd16777216;
		r.smp.frac_rain = 25'd16777216;
		r.smp.frac_ice = 25'd16777216;
		r.smp.frac_snow = 25'd16777216;
		r.smp.frac_graupel = 25'd16777216;
		rows.push_back(r);
		r.smp = '1;
		rows.push_back(r);
		r.smp = z;
		r.smp.air_density = '1;
		r.smp.energy_density = 32'd50000000;
		rows.push_back(r);
		r.smp.frac_vapor = 25'd16777216;
		rows.push_back(r);
		r.smp = z;
		r.smp.energy_density = 32'd1;
		r.smp.air_density = 26'd1;
		rows.push_back(r);
		r.smp = '1;
		r.smp.frac_vapor = '0;
		r.smp.frac_cloud = '0;
		r.smp.frac_rain = '0;
		r.smp.frac_ice = '0;
		r.smp.frac_snow = '0;
		r.smp.frac_graupel = '0;
		rows.push_back(r);
	endtask

	task automatic set_phase_coefs(int phase);
		logic [31:0] v [6];
		case (phase)
			1: for (int i = 0; i < 6; i++) v[i] = 32'hFFFFFFFF;
			2: for (int i = 0; i < 6; i++) v[i] = 32'h0;
			3: begin
				v = '{32'h1FFFFFF, 32'h1FFFFFF, 32'd1, 32'd1, 32'd1, 32'd1};
			end
			7: begin
				v = '{32'(RST_CV_DRY), 32'(RST_GAS_DRY), 32'(RST_GAS_VAPOR),
					32'(RST_CV_VAPOR), 32'(RST_CV_LIQUID), 32'(RST_CV_ICE)};
			end
			default: for (int i = 0; i < 6; i++) v[i] = $urandom;
		endcase
		for (int i = 0; i < 6; i++)
			write_coef(i[2:0], v[i]);
		if (phase == 7) begin
			write_coef(REG_SPARE_A, $urandom);
			write_coef(REG_SPARE_B, $urandom);
		end
	endtask

	initial begin
		cell_row_t rows [$];
		bit bursty;
		coef[REG_CV_DRY]    = RST_CV_DRY;
		coef[REG_GAS_DRY]   = RST_GAS_DRY;
		coef[REG_GAS_VAPOR] = RST_GAS_VAPOR;
		coef[REG_CV_VAPOR]  = RST_CV_VAPOR;
		coef[REG_CV_LIQUID] = RST_CV_LIQUID;
		coef[REG_CV_ICE]    = RST_CV_ICE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_table(rows);
		foreach (rows[i])
			send_cell(rows[i].smp, rows[i].typed, rows[i].want);

		bursty = 1'b0;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase != 0) begin
				drain();
				set_phase_coefs(phase);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 40 == 0)
					bursty = $urandom_range(0, 1);
				// last phase runs back to back
				if (phase != NUM_PHASES - 1 && bursty && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 16)) @(posedge clk);
				end
				if (phase == 4 && n == ITEMS_PER_PHASE / 2)
					drain();
				send_cell(random_cell(), 1'b0, '0);
			end
		end

		drain();
		$display("covered %0d cells over %0d coefficient sets, %0d results checked",
			cells_sent, NUM_PHASES, results_seen);
		$display("including zero and full-scale coefficients and ignored register writes");
		if (errors == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/matp_pkg.sv
hw/rtl/matp_lane.sv
hw/rtl/matp_div.sv
hw/rtl/moist_air_temp_pressure.sv
tb/tb_top.sv
